@@ rtl/core/mwm_pkg.sv @@
// Shared constants, types and command/status bundles of the moving window median block.
package mwm_pkg;

  localparam int DEPTH   = 64;
  localparam int VAL_W   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IN_USER_W  = 3;
  localparam int OUT_USER_W = 2;
  localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_EMPTY     = 2'd1,
    RES_FULL      = 2'd2,
    RES_NOT_FOUND = 2'd3
  } res_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_Q_RD,
    S_Q_HI,
    S_Q_LO,
    S_Q_MEAN,
    S_RESULT
  } state_e;

  typedef enum logic [2:0] {
    RD_PTR_M1,
    RD_PTR,
    RD_PTR_P1,
    RD_MID,
    RD_MID_M1
  } rd_sel_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INC,
    OP_DEC
  } step_e;

  typedef enum logic [1:0] {
    MED_HOLD,
    MED_RDATA,
    MED_MEAN
  } med_sel_e;

  typedef struct packed {
    logic     ld;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    logic     wr_value;
    step_e    ptr_op;
    step_e    cnt_op;
    logic     res_set;
    res_e     res_val;
    med_sel_e med_sel;
    logic     hi_ld;
    logic     sum_ld;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_null;
    logic       cnt_zero;
    logic       cnt_full;
    logic       cnt_odd;
    logic       ptr_one;
    logic       ptr_last;
    logic       less;
    logic       equal;
    logic       avg;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/mwm_datapath.sv @@
// Datapath: sorted value store, pointer and count, median arithmetic and output register.
module mwm_datapath
  import mwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic [VAL_W-1:0]      in_value_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic [OUT_USER_W-1:0] m_user_o
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;
  logic [VAL_W-1:0] value_q, hi_q, median_q, median_d;
  logic [1:0]       cmd_q;
  logic             null_q;
  logic [CNT_W-1:0] ptr_q, ptr_d, cnt_q, cnt_d, rd_addr;
  logic [VAL_W:0]   sum_q, sum_adj;
  res_e             res_q;
  logic             avg_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_med_q;
  logic [CNT_W-1:0] out_cnt_q;
  res_e             out_res_q;

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] OneC   = CNT_W'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PTR_M1: rd_addr = ptr_q - OneC;
      RD_PTR:    rd_addr = ptr_q;
      RD_PTR_P1: rd_addr = ptr_q + OneC;
      RD_MID:    rd_addr = {1'b0, cnt_q[CNT_W-1:1]};
      RD_MID_M1: rd_addr = {1'b0, cnt_q[CNT_W-1:1]} - OneC;
      default:   rd_addr = ptr_q;
    endcase
  end

  // Single port style store: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[ptr_q[ADDR_W-1:0]] <= cmd_i.wr_value ? value_q : rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // Round the halved 65-bit sum toward zero.
  assign sum_adj = sum_q + {{VAL_W{1'b0}}, sum_q[VAL_W] & sum_q[0]};

  always_comb begin
    unique case (cmd_i.med_sel)
      MED_RDATA: median_d = rdata_q;
      MED_MEAN:  median_d = sum_adj[VAL_W:1];
      default:   median_d = median_q;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ld) begin
      ptr_d = (in_user_i[1:0] == CMD_INSERT) ? cnt_q : '0;
    end else begin
      unique case (cmd_i.ptr_op)
        OP_INC:  ptr_d = ptr_q + OneC;
        OP_DEC:  ptr_d = ptr_q - OneC;
        default: ptr_d = ptr_q;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      OP_INC:  cnt_d = cnt_q + OneC;
      OP_DEC:  cnt_d = cnt_q - OneC;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      value_q <= in_value_i;
      cmd_q   <= in_user_i[1:0];
      null_q  <= in_user_i[2];
    end
    ptr_q <= ptr_d;
    if (cmd_i.hi_ld) begin
      hi_q <= rdata_q;
    end
    if (cmd_i.sum_ld) begin
      sum_q <= {hi_q[VAL_W-1], hi_q} + {rdata_q[VAL_W-1], rdata_q};
    end
    if (cmd_i.ld) begin
      median_q <= '0;
      res_q    <= RES_OK;
    end else begin
      median_q <= median_d;
      if (cmd_i.res_set) begin
        res_q <= cmd_i.res_val;
      end
    end
    if (cmd_i.out_ld) begin
      out_med_q <= median_q;
      out_res_q <= res_q;
      out_cnt_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      avg_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        avg_q <= cfg_wdata_i;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.cmd      = cmd_q;
    sts_o.is_null  = null_q;
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.cnt_full = (cnt_q == DepthC);
    sts_o.cnt_odd  = cnt_q[0];
    sts_o.ptr_one  = (ptr_q == OneC);
    sts_o.ptr_last = ((ptr_q + OneC) == cnt_q);
    sts_o.less     = ($signed(value_q) < $signed(rdata_q));
    sts_o.equal    = (value_q == rdata_q);
    sts_o.avg      = avg_q;
    sts_o.out_free = !out_valid_q || m_ready_i;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(OUT_DATA_W - CNT_W - VAL_W){1'b0}}, out_cnt_q, out_med_q};
  assign m_user_o  = out_res_q;

endmodule

@@ rtl/core/mwm_controller.sv @@
// Controller: sequences insert, remove and query steps over the value store.
module mwm_controller
  import mwm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.cmd == CMD_INSERT && !sts_i.is_null) begin
          if (sts_i.cnt_full)      state_d = S_RESULT;
          else if (sts_i.cnt_zero) state_d = S_INS_PUT;
          else                     state_d = S_INS_RD;
        end else if (sts_i.cmd == CMD_REMOVE && !sts_i.is_null) begin
          state_d = sts_i.cnt_zero ? S_RESULT : S_REM_RD;
        end else if (sts_i.cmd == CMD_QUERY) begin
          state_d = sts_i.cnt_zero ? S_RESULT : S_Q_RD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (sts_i.less && !sts_i.ptr_one) state_d = S_INS_RD;
        else                              state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_RESULT;
      S_REM_RD:  state_d = S_REM_CMP;
      S_REM_CMP: begin
        if (sts_i.equal)         state_d = S_SH_RD;
        else if (sts_i.ptr_last) state_d = S_RESULT;
        else                     state_d = S_REM_RD;
      end
      S_SH_RD:   state_d = sts_i.ptr_last ? S_RESULT : S_SH_WR;
      S_SH_WR:   state_d = S_SH_RD;
      S_Q_RD:    state_d = S_Q_HI;
      S_Q_HI:    state_d = sts_i.cnt_odd ? S_RESULT : S_Q_LO;
      S_Q_LO:    state_d = sts_i.avg ? S_Q_MEAN : S_RESULT;
      S_Q_MEAN:  state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_PTR;
    cmd_o.ptr_op   = OP_HOLD;
    cmd_o.cnt_op   = OP_HOLD;
    cmd_o.res_val  = RES_OK;
    cmd_o.med_sel  = MED_HOLD;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.ld   = in_valid_i;
      end
      S_DISPATCH: begin
        if (sts_i.cmd == CMD_INSERT && !sts_i.is_null && sts_i.cnt_full) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = RES_FULL;
        end else if (sts_i.cmd == CMD_REMOVE && !sts_i.is_null && sts_i.cnt_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = RES_NOT_FOUND;
        end else if (sts_i.cmd == CMD_QUERY && sts_i.cnt_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = RES_EMPTY;
        end
      end
      S_INS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PTR_M1;
      end
      S_INS_CMP: begin
        if (sts_i.less) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.ptr_op = OP_DEC;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_value = 1'b1;
        cmd_o.cnt_op   = OP_INC;
      end
      S_REM_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_REM_CMP: begin
        if (!sts_i.equal) begin
          if (sts_i.ptr_last) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_val = RES_NOT_FOUND;
          end else begin
            cmd_o.ptr_op = OP_INC;
          end
        end
      end
      S_SH_RD: begin
        if (sts_i.ptr_last) begin
          cmd_o.cnt_op = OP_DEC;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_P1;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.ptr_op = OP_INC;
      end
      S_Q_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_MID;
      end
      S_Q_HI: begin
        if (sts_i.cnt_odd) begin
          cmd_o.med_sel = MED_RDATA;
        end else begin
          cmd_o.hi_ld  = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID_M1;
        end
      end
      S_Q_LO: begin
        if (sts_i.avg) cmd_o.sum_ld  = 1'b1;
        else           cmd_o.med_sel = MED_RDATA;
      end
      S_Q_MEAN: begin
        cmd_o.med_sel = MED_MEAN;
      end
      S_RESULT: begin
        cmd_o.out_ld = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/moving_window_median.sv @@
// Top level of the moving window median block: controller plus datapath.
//
// The block holds up to DEPTH (64) signed 64-bit values in ascending order in a
// single-port store with a registered read, and takes one command per input
// transaction: insert, remove one equal value, or query the median. Every
// command returns exactly one result transaction carrying the median (zero
// unless a query succeeds), a status code and the count held afterward. One
// command is in flight at a time; the next can be accepted while the previous
// result still waits on the output register. An insert reads the held values
// from the top down, moving each one up while the new value is smaller, then
// writes the new value; a remove scans upward for an equal value, then shifts
// each later value down with a read and a write; a query reads the middle value
// (the upper middle one for an even count) and, for an even count, the lower
// middle one, which it returns alone or averaged with the upper one. Null inserts
// and removes, full inserts, empty removes and queries, and unused commands go
// straight to the result. Each compare or shift step waits on the registered
// store read.
// The store is not cleared after reset; only written entries are ever read.
// The average_even register (reset 1) is written through cfg_we_i/cfg_wdata_i
// and must only change while the block is idle.
module moving_window_median
  import mwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,     // average_even
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,    // [63:0] value
  input  logic [IN_USER_W-1:0]  s_axis_tuser,    // [1:0] cmd, [2] value_null
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,    // [63:0] median, [70:64] held_count
  output logic [OUT_USER_W-1:0] m_axis_tuser     // [1:0] status
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence each command as a series of store read, compare and write steps.
  mwm_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Hold the sorted values, count, median arithmetic and result register.
  mwm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

@@ rtl/core/mwm_checker.sv @@
// Port-level checker for the moving window median block, bound to the top level.
module mwm_checker
  import mwm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Take one command at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[VAL_W +: CNT_W] <= DepthC)
    else $error("held count beyond depth");

  a_err_zero_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != RES_OK |-> m_axis_tdata[VAL_W-1:0] == '0)
    else $error("nonzero median with error status");

  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser != RES_FULL || m_axis_tdata[VAL_W +: CNT_W] == DepthC) &&
      (m_axis_tuser != RES_EMPTY || m_axis_tdata[VAL_W +: CNT_W] == '0))
    else $error("status disagrees with held count");

endmodule

bind moving_window_median mwm_checker u_mwm_checker (.*);
